[hw/rtl/flow_group_completion_tracker_unit_assert.svh]
// Assertion macros used by the flow group tracker checker.
`ifndef FLOW_GROUP_COMPLETION_TRACKER_UNIT_ASSERT_SVH
`define FLOW_GROUP_COMPLETION_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define FGCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define FGCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fgct_pkg.sv]
// Types and constants of the flow group completion tracker.
package fgct_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READY    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COMPLETE = 3'd4;

  // register index of flow_count
  localparam logic REG_FLOW_COUNT = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_READY,
    OP_RELEASE,
    OP_COMPLETE
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DEP  = 2'd1,
    ERR_DUP  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_RELEASED = 2'd1,
    ST_COMPLETE = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] entry_index;
    logic [ID_W-1:0]   flow_id;
    logic [TIME_W-1:0] event_time;
  } cmd_t;

  typedef struct packed {
    err_e              error_code;
    logic              group_done_now;
    status_e           group_status;
    logic [CNT_W-1:0]  done_count;
    logic              ready_seen;
    logic [TIME_W-1:0] ready_time;
    logic [TIME_W-1:0] release_time;
    logic [TIME_W-1:0] finish_time;
  } res_t;

endpackage

[hw/rtl/flow_group_completion_tracker_unit.sv]
// Flow group completion tracker: top level with config register and ports.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one item per action:
//    clear run, load table entry, dependency ready, release, flow complete.
//  - Output channel (out_valid_o / out_stall_i) returns exactly one result
//    item per input item, in order, with the run status after the action.
//  - APB port holds flow_count at byte address 0 (reset 1); write it only
//    while no item is in flight.
// Timing: each item passes the command queue and the result register. A
//  completion scans the table from slot 0 until its id matches; a miss scans
//  n entries, n = min(flow_count, MAX_FLOWS). The table is scanned one entry
//  per cycle through the member table RAM read port, which sets the completion
//  throughput; other actions sustain one per cycle while out_stall_i is low.
// A two-entry queue between decode and execute keeps the input taking items
//  while a result waits in the output register.
// Reset clears run state and done bits and sets flow_count to 1; table
//  contents are undefined until loaded. A stalled result holds; once the
//  queue fills, in_stall_o rises.
module flow_group_completion_tracker_unit #(
  parameter int unsigned MAX_FLOWS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fgct_pkg::ACT_W-1:0]         action_i,
  input  logic [fgct_pkg::SLOT_W-1:0]        entry_index_i,
  input  logic [fgct_pkg::ID_W-1:0]          flow_id_i,
  input  logic [fgct_pkg::TIME_W-1:0]        event_time_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         error_code_o,
  output logic                               group_done_now_o,
  output logic [1:0]                         group_status_o,
  output logic [fgct_pkg::CNT_W-1:0]         done_count_o,
  output logic                               ready_seen_o,
  output logic [fgct_pkg::TIME_W-1:0]        ready_time_o,
  output logic [fgct_pkg::TIME_W-1:0]        release_time_o,
  output logic [fgct_pkg::TIME_W-1:0]        finish_time_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fgct_pkg::CFG_AW-1:0]        paddr,
  input  logic [fgct_pkg::CFG_DW-1:0]        pwdata,
  output logic [fgct_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);

  logic [fgct_pkg::CNT_W-1:0] flow_count_q;
  logic                       q_valid, q_pop;
  fgct_pkg::cmd_t             q_cmd;
  fgct_pkg::res_t             res;

  // register index is the word address; only index 0 exists
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fgct_pkg::REG_FLOW_COUNT)
                  ? fgct_pkg::CFG_DW'(flow_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_count_q <= fgct_pkg::CNT_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == fgct_pkg::REG_FLOW_COUNT)) begin
      flow_count_q <= pwdata[fgct_pkg::CNT_W-1:0];
    end
  end

  fgct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .flow_id_i     (flow_id_i),
    .event_time_i  (event_time_i),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_cmd_o       (q_cmd)
  );

  fgct_back #(
    .MAX_FLOWS (MAX_FLOWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_cmd_i      (q_cmd),
    .flow_count_i (flow_count_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign error_code_o     = res.error_code;
  assign group_done_now_o = res.group_done_now;
  assign group_status_o   = res.group_status;
  assign done_count_o     = res.done_count;
  assign ready_seen_o     = res.ready_seen;
  assign ready_time_o     = res.ready_time;
  assign release_time_o   = res.release_time;
  assign finish_time_o    = res.finish_time;

endmodule

[hw/rtl/fgct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fgct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fgct_front.sv]
// Front end: takes input items, decodes the action, queues commands.
module fgct_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [fgct_pkg::ACT_W-1:0]         action_i,
  input  logic [fgct_pkg::SLOT_W-1:0]        entry_index_i,
  input  logic [fgct_pkg::ID_W-1:0]          flow_id_i,
  input  logic [fgct_pkg::TIME_W-1:0]        event_time_i,
  output logic                               q_valid_o,
  input  logic                               q_pop_i,
  output fgct_pkg::cmd_t                     q_cmd_o
);

  fgct_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  fgct_pkg::cmd_t cmd;
  logic           push, pop;

  always_comb begin
    cmd.entry_index = entry_index_i;
    cmd.flow_id     = flow_id_i;
    cmd.event_time  = event_time_i;
    case (action_i)
      fgct_pkg::ACT_CLEAR:    cmd.op = fgct_pkg::OP_CLEAR;
      fgct_pkg::ACT_LOAD:     cmd.op = fgct_pkg::OP_LOAD;
      fgct_pkg::ACT_READY:    cmd.op = fgct_pkg::OP_READY;
      fgct_pkg::ACT_RELEASE:  cmd.op = fgct_pkg::OP_RELEASE;
      fgct_pkg::ACT_COMPLETE: cmd.op = fgct_pkg::OP_COMPLETE;
      default:                cmd.op = fgct_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

[hw/rtl/fgct_back.sv]
// Back end: run state, member table scan and the result register.
module fgct_back #(
  parameter int unsigned MAX_FLOWS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  fgct_pkg::cmd_t              q_cmd_i,
  input  logic [fgct_pkg::CNT_W-1:0]  flow_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fgct_pkg::res_t              res_o
);

  // flow_count never exceeds 127, so entries past 128 are never in use
  localparam int unsigned DEPTH = (MAX_FLOWS < 128) ? MAX_FLOWS : 128;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = fgct_pkg::TIME_W;
  localparam int unsigned CW    = fgct_pkg::CNT_W;

  fgct_pkg::back_state_e state_q, state_d;
  logic [DEPTH-1:0]  done_bits_q, done_bits_d;
  logic [CW-1:0]     tally_q, tally_d;
  logic              ready_q, ready_d, rel_q, rel_d, cmp_q, cmp_d;
  logic [TW-1:0]     ready_t_q, ready_t_d, rel_t_q, rel_t_d, cmp_t_q, cmp_t_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [fgct_pkg::ID_W-1:0] key_id_q, key_id_d;
  logic [TW-1:0]     key_t_q, key_t_d;
  logic              out_valid_q, out_valid_d;
  fgct_pkg::res_t    res_q, res_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [fgct_pkg::ID_W-1:0] ram_wdata, ram_rdata;

  logic              out_free, emit, done_now, last;
  fgct_pkg::err_e    err;
  logic [CW-1:0]     n_used;

  fgct_ram #(
    .WIDTH (fgct_pkg::ID_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign n_used   = (32'(flow_count_i) > DEPTH) ? CW'(DEPTH) : flow_count_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (32'(idx_q) + 32'd1) >= 32'(n_used);

  always_comb begin
    state_d     = state_q;
    done_bits_d = done_bits_q;
    tally_d     = tally_q;
    ready_d     = ready_q;
    ready_t_d   = ready_t_q;
    rel_d       = rel_q;
    rel_t_d     = rel_t_q;
    cmp_d       = cmp_q;
    cmp_t_d     = cmp_t_q;
    idx_d       = idx_q;
    key_id_d    = key_id_q;
    key_t_d     = key_t_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(q_cmd_i.entry_index);
    ram_wdata   = q_cmd_i.flow_id;
    ram_raddr   = '0;
    emit        = 1'b0;
    done_now    = 1'b0;
    err         = fgct_pkg::ERR_NONE;

    case (state_q)
      fgct_pkg::BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            fgct_pkg::OP_CLEAR: begin
              done_bits_d = '0;
              tally_d     = '0;
              ready_d     = 1'b0;
              ready_t_d   = '0;
              rel_d       = 1'b0;
              rel_t_d     = '0;
              cmp_d       = 1'b0;
              cmp_t_d     = '0;
              emit        = 1'b1;
            end
            fgct_pkg::OP_LOAD: begin
              ram_we = (32'(q_cmd_i.entry_index) < MAX_FLOWS);
              emit   = 1'b1;
            end
            fgct_pkg::OP_READY: begin
              if (ready_q) begin
                err = fgct_pkg::ERR_DEP;
              end else begin
                ready_d   = 1'b1;
                ready_t_d = q_cmd_i.event_time;
              end
              emit = 1'b1;
            end
            fgct_pkg::OP_RELEASE: begin
              if (!ready_q || rel_q || (q_cmd_i.event_time < ready_t_q)) begin
                err = fgct_pkg::ERR_DEP;
              end else begin
                rel_d   = 1'b1;
                rel_t_d = q_cmd_i.event_time;
              end
              emit = 1'b1;
            end
            fgct_pkg::OP_COMPLETE: begin
              if (!rel_q || cmp_q || (n_used == '0)) begin
                err  = fgct_pkg::ERR_DEP;
                emit = 1'b1;
              end else begin
                // start the scan at slot 0; data comes back next cycle
                key_id_d = q_cmd_i.flow_id;
                key_t_d  = q_cmd_i.event_time;
                idx_d    = '0;
                state_d  = fgct_pkg::BK_SCAN;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      fgct_pkg::BK_SCAN: begin
        if (ram_rdata == key_id_q) begin
          if (done_bits_q[idx_q]) begin
            err = fgct_pkg::ERR_DUP;
          end else begin
            done_bits_d[idx_q] = 1'b1;
            tally_d            = tally_q + CW'(1);
            if (tally_d == n_used) begin
              cmp_d    = 1'b1;
              cmp_t_d  = key_t_q;
              done_now = 1'b1;
            end
          end
          emit    = 1'b1;
          state_d = fgct_pkg::BK_IDLE;
        end else if (last) begin
          err     = fgct_pkg::ERR_DEP;
          emit    = 1'b1;
          state_d = fgct_pkg::BK_IDLE;
        end else begin
          idx_d     = AW'(32'(idx_q) + 32'd1);
          ram_raddr = idx_d;
        end
      end
      default: begin
        state_d = fgct_pkg::BK_IDLE;
      end
    endcase

    // result shows the state after the action
    if (emit) begin
      out_valid_d          = 1'b1;
      res_d.error_code     = err;
      res_d.group_done_now = done_now;
      res_d.group_status   = cmp_d ? fgct_pkg::ST_COMPLETE :
                             (rel_d ? fgct_pkg::ST_RELEASED : fgct_pkg::ST_PENDING);
      res_d.done_count     = tally_d;
      res_d.ready_seen     = ready_d;
      res_d.ready_time     = ready_t_d;
      res_d.release_time   = rel_t_d;
      res_d.finish_time    = cmp_t_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fgct_pkg::BK_IDLE;
      done_bits_q <= '0;
      tally_q     <= '0;
      ready_q     <= 1'b0;
      ready_t_q   <= '0;
      rel_q       <= 1'b0;
      rel_t_q     <= '0;
      cmp_q       <= 1'b0;
      cmp_t_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_bits_q <= done_bits_d;
      tally_q     <= tally_d;
      ready_q     <= ready_d;
      ready_t_q   <= ready_t_d;
      rel_q       <= rel_d;
      rel_t_q     <= rel_t_d;
      cmp_q       <= cmp_d;
      cmp_t_q     <= cmp_t_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_id_q <= key_id_d;
    key_t_q  <= key_t_d;
    res_q    <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/fgct_checker.sv]
// Port-level checker for the flow group tracker, bound to the top level.
`include "flow_group_completion_tracker_unit_assert.svh"

module fgct_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 error_code_o,
  input logic                       group_done_now_o,
  input logic [1:0]                 group_status_o,
  input logic [fgct_pkg::CNT_W-1:0] done_count_o,
  input logic                       ready_seen_o
);

  `FGCT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  `FGCT_ASSERT_NOW(a_done_now_complete, out_valid_o && group_done_now_o, (group_status_o == fgct_pkg::ST_COMPLETE) && (error_code_o == fgct_pkg::ERR_NONE) && (done_count_o != '0), "group done without completion")

  `FGCT_ASSERT_NOW(a_dup_released, out_valid_o && (error_code_o == fgct_pkg::ERR_DUP), group_status_o == fgct_pkg::ST_RELEASED, "duplicate outside released group")

  `FGCT_ASSERT_NOW(a_release_needs_ready, out_valid_o && (group_status_o != fgct_pkg::ST_PENDING), ready_seen_o, "released without ready")

endmodule

bind flow_group_completion_tracker_unit fgct_checker u_fgct_checker (.*);
